// ===== hw/rtl/fermat_pkg.sv =====
package fermat_pkg;

	// sequencer states of the factor search
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT_N,
		ST_ROOT_GAP,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/fermat_in_if.sv =====
interface fermat_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

// ===== hw/rtl/fermat_out_if.sv =====
interface fermat_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-2:0] factor_high;
	logic [DATA_WIDTH-2:0] factor_low;

	modport source (output valid, output factor_high, output factor_low, input ready);
	modport sink (input valid, input factor_high, input factor_low, output ready);
endinterface

// ===== hw/rtl/fermat_isqrt.sv =====
module fermat_isqrt #(
	parameter int WIDTH = 32,
	localparam int PAIRS = (WIDTH + 1) / 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] value,
	output logic             done,
	output logic [PAIRS-1:0] root,
	output logic [PAIRS+1:0] rem
);

	localparam int CW = $clog2(PAIRS + 1);

	logic [2*PAIRS-1:0] val_q;
	logic [PAIRS-1:0]   root_q;
	logic [PAIRS+1:0]   rem_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;

	logic [PAIRS+1:0]   rem_sh;
	logic [PAIRS+1:0]   trial;
	logic               ge;

	// one root digit per cycle: bring down two bits, try 4*root+1
	assign rem_sh = {rem_q[PAIRS-1:0], val_q[2*PAIRS-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	// digit counter and finish pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(PAIRS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	// operand shifter, partial root and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= (2*PAIRS)'(value);
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			val_q  <= {val_q[2*PAIRS-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[PAIRS-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/fermat_factorizer_core.sv =====
// Fermat factorizer: takes one signed DATA_WIDTH-bit number per item and returns
// two factors. Zero and negative numbers give 0 and 0, even numbers give 2 and n/2.
// Odd numbers run Fermat's search: x starts at the ceiling square root of n and
// steps up until x*x-n is a perfect square y*y, giving x+y and x-y; if x*x-n passes
// the largest positive value the result is n and 1. Every square root goes through
// one shared digit-by-digit unit. The gap x*x-n is kept up to date by adding 2x+1
// at each step, with no multiplier. One item is in work at a time; a new item is
// taken while the last result still waits in the output register.
module fermat_factorizer_core #(
	parameter int DATA_WIDTH = 32
) (
	input logic             clk,
	input logic             arst_n,
	fermat_in_if.sink       operand,
	fermat_out_if.source    result
);

	import fermat_pkg::*;

	localparam int PAIRS = (DATA_WIDTH + 1) / 2;
	localparam int XW    = PAIRS + 1;
	localparam int OW    = DATA_WIDTH - 1;

	state_t                state_q;
	state_t                state_d;

	logic [DATA_WIDTH-1:0] n_q;
	logic [XW-1:0]         x_q;
	logic [DATA_WIDTH-1:0] gap_q;
	logic [OW-1:0]         hi_q;
	logic [OW-1:0]         lo_q;
	logic [OW-1:0]         fh_q;
	logic [OW-1:0]         fl_q;
	logic                  out_valid_q;

	logic                  sq_start;
	logic [DATA_WIDTH-1:0] sq_value;
	logic                  sq_done;
	logic [PAIRS-1:0]      sq_root;
	logic [PAIRS+1:0]      sq_rem;

	logic [DATA_WIDTH-1:0] raw;
	logic                  in_acc;
	logic                  non_pos;
	logic                  out_free;
	logic                  rem_zero;
	logic [DATA_WIDTH-1:0] root_ext;
	logic [XW-1:0]         x_init;
	logic [DATA_WIDTH-1:0] gap_init;
	logic [DATA_WIDTH-1:0] gap_step;
	logic                  gap_ovf;
	logic [DATA_WIDTH-1:0] sum;
	logic [DATA_WIDTH-1:0] diff;

	// shared square-root unit
	fermat_isqrt #(
		.WIDTH (DATA_WIDTH)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_value),
		.done   (sq_done),
		.root   (sq_root),
		.rem    (sq_rem)
	);

	// item decode
	assign raw     = operand.number;
	assign in_acc  = operand.valid && operand.ready;
	assign non_pos = (raw == '0) || raw[DATA_WIDTH-1];
	assign out_free = !out_valid_q || result.ready;

	// start point: x = ceil(sqrt(n)), gap = x*x - n = 2s+1-r when r is nonzero
	assign rem_zero = (sq_rem == '0);
	assign root_ext = DATA_WIDTH'(sq_root);
	assign x_init   = rem_zero ? XW'(sq_root) : (XW'(sq_root) + XW'(1));
	assign gap_init = rem_zero ? '0 : ({root_ext[DATA_WIDTH-2:0], 1'b1} - DATA_WIDTH'(sq_rem));

	// next x: gap grows by 2x+1
	assign gap_step = gap_q + DATA_WIDTH'({x_q, 1'b1});
	assign gap_ovf  = gap_step[DATA_WIDTH-1];

	// factors from x and y
	assign sum  = DATA_WIDTH'(x_q) + root_ext;
	assign diff = DATA_WIDTH'(x_q) - root_ext;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (!non_pos && raw[0]) ? ST_ROOT_N : ST_DONE;
				end
			end
			ST_ROOT_N: begin
				if (sq_done) begin
					state_d = ST_ROOT_GAP;
				end
			end
			ST_ROOT_GAP: begin
				if (sq_done && (rem_zero || gap_ovf)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		operand.ready = 1'b0;
		sq_start      = 1'b0;
		sq_value      = gap_step;
		unique case (state_q)
			ST_IDLE: begin
				operand.ready = 1'b1;
				sq_start      = in_acc && !non_pos && raw[0];
				sq_value      = raw;
			end
			ST_ROOT_N: begin
				sq_start = sq_done;
				sq_value = gap_init;
			end
			ST_ROOT_GAP: begin
				sq_start = sq_done && !rem_zero && !gap_ovf;
				sq_value = gap_step;
			end
			ST_DONE: begin
				sq_start = 1'b0;
			end
			default: sq_start = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					n_q <= raw;
					if (non_pos) begin
						hi_q <= '0;
						lo_q <= '0;
					end else begin
						hi_q <= OW'(2);
						lo_q <= raw[DATA_WIDTH-1:1];
					end
				end
			end
			ST_ROOT_N: begin
				if (sq_done) begin
					x_q   <= x_init;
					gap_q <= gap_init;
				end
			end
			ST_ROOT_GAP: begin
				if (sq_done) begin
					if (rem_zero) begin
						hi_q <= sum[OW-1:0];
						lo_q <= diff[OW-1:0];
					end else if (gap_ovf) begin
						hi_q <= n_q[OW-1:0];
						lo_q <= OW'(1);
					end else begin
						x_q   <= x_q + XW'(1);
						gap_q <= gap_step;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					fh_q <= hi_q;
					fl_q <= lo_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid       = out_valid_q;
	assign result.factor_high = fh_q;
	assign result.factor_low  = fl_q;

	// root unit only reports while the sequencer waits for it
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_ROOT_N || state_q == ST_ROOT_GAP))
		else $error("square root finished outside the search");

	// gap stays non-negative and x nonzero while the search runs
	a_gap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT_GAP) |-> (!gap_q[DATA_WIDTH-1] && x_q != '0))
		else $error("search gap or x out of range");

	// a finished item reaches the output register and frees the block
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("result not handed to output register");

	// outside idle, a new root starts only when the unit reports done
	a_start_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_start && state_q != ST_IDLE) |-> sq_done)
		else $error("square root restarted mid-run");

endmodule

// ===== tb/fermat_factorizer_core_tb.sv =====
`timescale 1ns / 100ps

module fermat_factorizer_core_tb;

	localparam int DATA_WIDTH = 32;
	localparam int FW = DATA_WIDTH - 1;
	localparam longint unsigned POS_MAX = (64'd1 << (DATA_WIDTH - 1)) - 1;
	localparam int IDLE_PCT = 35;
	localparam int RANDOM_ITEMS = 100;
	localparam int DRAIN_CYCLES = 40;
	// one overflow search runs about 20k steps, the rest far less
	localparam longint CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		logic [FW-1:0] high;
		logic [FW-1:0] low;
	} factor_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fermat_in_if #(.DATA_WIDTH(DATA_WIDTH)) operand_ch ();
	fermat_out_if #(.DATA_WIDTH(DATA_WIDTH)) result_ch ();

	fermat_factorizer_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_ch.sink),
		.result(result_ch.source)
	);

	logic [DATA_WIDTH-1:0] numbers_to_send[$];
	factor_pair_t factors_due[$];
	int numbers_sent = 0;
	int factors_checked = 0;
	int mismatches = 0;
	longint cycle_count = 0;
	logic steady;

	// no idling on either side for a stretch in the middle of the run
	assign steady = (numbers_sent >= 40) && (numbers_sent < 60);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// floor square root, one result bit at a time from the top
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			longint unsigned trial;
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// factor pair that the block must return for one number
	function automatic factor_pair_t fermat_factors(logic [DATA_WIDTH-1:0] number);
		longint unsigned n;
		longint unsigned x;
		longint unsigned y;
		longint unsigned gap;
		longint unsigned hi;
		longint unsigned lo;
		factor_pair_t pair;
		n = number;
		if (n == 0 || number[DATA_WIDTH-1]) begin
			hi = 0;
			lo = 0;
		end else if (!number[0]) begin
			hi = 2;
			lo = n >> 1;
		end else begin
			x = floor_root(n);
			if (x * x < n)
				x++;
			gap = x * x - n;
			forever begin
				y = floor_root(gap);
				if (y * y == gap) begin
					hi = x + y;
					lo = x - y;
					break;
				end
				x++;
				gap = x * x - n;
				if (gap > POS_MAX) begin
					hi = n;
					lo = 1;
					break;
				end
			end
		end
		pair.high = hi[FW-1:0];
		pair.low = lo[FW-1:0];
		return pair;
	endfunction

	// random number: signs, evens, small odds and products of close odd factors
	function automatic logic [DATA_WIDTH-1:0] random_number();
		int pick;
		longint unsigned a;
		longint unsigned b;
		longint unsigned d;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		else if (pick < 15)
			return $urandom | 32'h8000_0000;
		else if (pick < 45)
			return $urandom & 32'h7fff_fffe;
		else if (pick < 70)
			return $urandom_range(1023) | 32'h1;
		a = 2 * $urandom_range(23169, 1) + 1;
		d = 2 * $urandom_range(500);
		b = a + d;
		if (a * b > POS_MAX)
			b = a - d;
		return DATA_WIDTH'(a * b);
	endfunction

	// input driver: holds each item until taken, idles at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (operand_ch.valid && operand_ch.ready) begin
				factors_due.push_back(fermat_factors(operand_ch.number));
				numbers_sent <= numbers_sent + 1;
			end
			if (!operand_ch.valid || operand_ch.ready) begin
				if (numbers_to_send.size() > 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					operand_ch.valid <= 1'b1;
					operand_ch.number <= numbers_to_send.pop_front();
				end else begin
					operand_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random back-pressure, compare with the oldest expected pair
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (factors_due.size() == 0) begin
					$error("result with no item outstanding: high %0d low %0d",
						result_ch.factor_high, result_ch.factor_low);
					mismatches++;
				end else begin
					factor_pair_t want;
					want = factors_due.pop_front();
					if (result_ch.factor_high !== want.high) begin
						$error("factor_high: expected %0d, got %0d", want.high,
							result_ch.factor_high);
						mismatches++;
					end
					if (result_ch.factor_low !== want.low) begin
						$error("factor_low: expected %0d, got %0d", want.low,
							result_ch.factor_low);
						mismatches++;
					end
				end
				factors_checked <= factors_checked + 1;
			end
			result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				factors_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		operand_ch.valid = 1'b0;
		operand_ch.number = '0;
		result_ch.ready = 1'b0;

		// directed: signs, evens, tiny odds, squares, close factors, overflow fallback
		numbers_to_send.push_back(32'd0);
		numbers_to_send.push_back(32'hffff_ffff);
		numbers_to_send.push_back(32'h8000_0000);
		numbers_to_send.push_back(32'h8000_0002);
		numbers_to_send.push_back(32'd2);
		numbers_to_send.push_back(32'd4);
		numbers_to_send.push_back(32'h7fff_fffe);
		numbers_to_send.push_back(32'd1);
		numbers_to_send.push_back(32'd3);
		numbers_to_send.push_back(32'd9);
		numbers_to_send.push_back(32'd15);
		numbers_to_send.push_back(32'd21);
		numbers_to_send.push_back(32'd46339 * 32'd46339);
		numbers_to_send.push_back(32'd46337 * 32'd46339);
		numbers_to_send.push_back(32'h7fff_ffff);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// hold off until the directed items are all answered
		while (numbers_to_send.size() > 0 || operand_ch.valid || factors_due.size() > 0)
			@(negedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			numbers_to_send.push_back(random_number());

		while (numbers_to_send.size() > 0 || operand_ch.valid || factors_due.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d numbers factored, %0d results compared in %0d cycles", numbers_sent,
			factors_checked, cycle_count);
		$display("covered signs, evens, odd searches, squares and the overflow fallback");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
